>>> hw/rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: field widths, beat layouts,
// configuration register indexes, status codes and reset values.
// No dependencies.
package fbpa_pkg;

  // Parameter defaults
  localparam int MAX_BLOCKS_DEF   = 1024;
  localparam int ADDRESS_BITS_DEF = 32;

  // Field widths
  localparam int REQ_W     = 17;
  localparam int FADDR_W   = 32;
  localparam int BSIZE_W   = 17;
  localparam int BCOUNT_W  = 11;
  localparam int BASE_W    = 32;
  localparam int BADDR_W   = 32;
  localparam int BYTES_W   = 27;
  localparam int BLOCKS_W  = 11;
  localparam int TOTAL_W   = 32;
  localparam int STATUS_W  = 3;

  // Beat layouts
  localparam int IN_TDATA_W  = 56;   // request_size, free_address, zero pad
  localparam int OUT_TDATA_W = 136;  // address, four counters, zero pad
  localparam int OUT_USED_W  = BADDR_W + BYTES_W + BLOCKS_W + 2 * TOTAL_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARENA_BASE  = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_BLOCK_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic [BASE_W-1:0]   ARENA_BASE_RST  = '0;
  localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd64;
  localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_OOM       = 3'd3,
    ST_BAD_PTR   = 3'd4
  } status_t;

endpackage

>>> hw/rtl/fbpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// Fixed block pool allocator top level: sequencer, shared add/subtract unit,
// multiplier, free-list link RAM and recorded-size RAM.
// Depends on fbpa_pkg and fbpa_ram.
//
// Hands out equal blocks of an arena from a LIFO free list (freed blocks first,
// then never-used blocks in ascending order) and takes them back on free.
// One request is worked at a time; the input is ready again once the result is
// placed in the output register, so a new request may enter while a result
// still waits. An allocate steps through decode, a pop of the free list when
// it holds a block, multiply and add; an error found on decode goes straight
// to the emit step. A free finds the block index one quotient bit per cycle on
// the shared subtractor after a limit check against the clipped block_count *
// block_size. Configuration writes are always taken and must only come while idle.
// No clearing pass is needed after reset.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS   = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDRESS_BITS = fbpa_pkg::ADDRESS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]   in_tdata,  // request_size, free_address
  input  logic                              in_tuser,  // mode
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // block_address, bytes_in_use, blocks_in_use, allocations_total, frees_total
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [fbpa_pkg::STATUS_W-1:0]     out_tuser  // status
);
  import fbpa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);   // holds the empty marker
  localparam int AW     = $clog2(MAX_BLOCKS);       // RAM address, quotient
  localparam int PW     = IDX_W + BSIZE_W;          // product width
  localparam int RW     = AW + BSIZE_W;             // division remainder
  localparam int AW_MAX = (ADDRESS_BITS > BADDR_W) ? ADDRESS_BITS : BADDR_W;
  localparam int W      = (AW_MAX > PW) ? AW_MAX : PW;
  localparam int CMP_W  = (IDX_W > BCOUNT_W) ? IDX_W : BCOUNT_W;
  localparam int CW     = (AW > 1) ? $clog2(AW) : 1;

  localparam logic [IDX_W-1:0] EMPTY   = IDX_W'(MAX_BLOCKS);
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BLOCKS);
  localparam logic [W-1:0]     AB_MASK = {W{1'b1}} >> (W - ADDRESS_BITS);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_POP    = 11'b000_0000_0100,
    S_AMUL   = 11'b000_0000_1000,
    S_AADD   = 11'b000_0001_0000,
    S_FMUL   = 11'b000_0010_0000,
    S_FCHK   = 11'b000_0100_0000,
    S_FDIV   = 11'b000_1000_0000,
    S_FREM   = 11'b001_0000_0000,
    S_FRD    = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t               state_r;

  // configuration
  logic [BASE_W-1:0]    base_r;
  logic [BSIZE_W-1:0]   bsize_r;
  logic [BCOUNT_W-1:0]  bcount_r;

  // allocator state
  logic [IDX_W-1:0]     free_head_r;
  logic [IDX_W-1:0]     untouched_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic [BLOCKS_W-1:0]  blocks_r;
  logic [TOTAL_W-1:0]   allocs_r;
  logic [TOTAL_W-1:0]   frees_r;

  // working registers
  logic                 mode_r;
  logic [REQ_W-1:0]     req_r;
  logic [FADDR_W-1:0]   faddr_r;
  logic [IDX_W-1:0]     idx_r;
  logic [PW-1:0]        prod_r;
  logic [W-1:0]         offset_r;
  logic [RW-1:0]        rem_r;
  logic [RW-1:0]        div_r;
  logic [AW-1:0]        quo_r;
  logic [CW-1:0]        cnt_r;
  status_t              res_status_r;
  logic [BADDR_W-1:0]   res_addr_r;

  // output register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [BADDR_W-1:0]   out_addr_r;
  logic [BYTES_W-1:0]   out_bytes_r;
  logic [BLOCKS_W-1:0]  out_blocks_r;
  logic [TOTAL_W-1:0]   out_allocs_r;
  logic [TOTAL_W-1:0]   out_frees_r;

  // shared units
  logic [W-1:0]         alu_a;
  logic [W-1:0]         alu_b;
  logic                 alu_sub;
  logic [W:0]           alu_res;
  logic                 alu_carry;
  logic [W-1:0]         alu_masked;
  logic [IDX_W-1:0]     mul_a;
  logic [PW-1:0]        mul_p;
  logic [CMP_W-1:0]     active_cmp;
  logic [IDX_W-1:0]     active;

  // RAM ports
  logic                 link_wr_en;
  logic [IDX_W-1:0]     link_wr_data;
  logic [IDX_W-1:0]     link_rd_data;
  logic                 size_wr_en;
  logic [BSIZE_W-1:0]   size_wr_data;
  logic [BSIZE_W-1:0]   size_rd_data;

  logic                 in_fire;
  logic                 cfg_fire;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid & cfg_ready;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;

  // Block count clipped to the pool size
  assign active_cmp = (CMP_W'(bcount_r) > MAX_CMP) ? MAX_CMP : CMP_W'(bcount_r);
  assign active     = IDX_W'(active_cmp);

  // Shared add/subtract unit; carry out on subtract means a >= b
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_DECODE: begin
        alu_a   = W'(faddr_r);
        alu_b   = W'(base_r);
        alu_sub = 1'b1;
      end
      S_FCHK: begin
        alu_a   = offset_r;
        alu_b   = W'(prod_r);
        alu_sub = 1'b1;
      end
      S_FDIV: begin
        alu_a   = W'(rem_r);
        alu_b   = W'(div_r);
        alu_sub = 1'b1;
      end
      S_AADD: begin
        alu_a   = W'(base_r);
        alu_b   = W'(prod_r);
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (W + 1)'(alu_sub);
  assign alu_carry  = alu_res[W];
  assign alu_masked = alu_res[W-1:0] & AB_MASK;

  // Shared multiplier: pool limit on free, block offset on allocate
  assign mul_a = (state_r == S_FMUL) ? active : idx_r;
  assign mul_p = PW'(mul_a) * PW'(bsize_r);

  // RAM write control; an allocate sets the block's link to the empty marker,
  // and a free links the block to the old free-list head
  assign link_wr_en   = (state_r == S_AMUL) || (state_r == S_FRD);
  assign link_wr_data = (state_r == S_AMUL) ? EMPTY : free_head_r;
  assign size_wr_en   = (state_r == S_AMUL) || (state_r == S_FRD);
  assign size_wr_data = (state_r == S_AMUL) ? req_r : '0;

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (idx_r[AW-1:0]),
    .wr_data (link_wr_data),
    .rd_addr (free_head_r[AW-1:0]),
    .rd_data (link_rd_data)
  );

  fbpa_ram #(
    .WIDTH (BSIZE_W),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (size_wr_en),
    .wr_addr (idx_r[AW-1:0]),
    .wr_data (size_wr_data),
    .rd_addr (quo_r),
    .rd_data (size_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= ARENA_BASE_RST;
      bsize_r     <= BLOCK_SIZE_RST;
      bcount_r    <= BLOCK_COUNT_RST;
      free_head_r <= EMPTY;
      untouched_r <= '0;
      bytes_r     <= '0;
      blocks_r    <= '0;
      allocs_r    <= '0;
      frees_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          CFG_ARENA_BASE:  base_r   <= cfg_data[BASE_W-1:0];
          CFG_BLOCK_SIZE:  bsize_r  <= cfg_data[BSIZE_W-1:0];
          CFG_BLOCK_COUNT: bcount_r <= cfg_data[BCOUNT_W-1:0];
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end

      // the emit step drives the valid itself
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r  <= in_tuser;
            req_r   <= in_tdata[REQ_W-1:0];
            faddr_r <= in_tdata[REQ_W +: FADDR_W];
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_addr_r <= '0;
          if (mode_r) begin
            offset_r <= alu_masked;
            state_r  <= S_FMUL;
          end else if (req_r == '0) begin
            res_status_r <= ST_NULL;
            state_r      <= S_EMIT;
          end else if (req_r > bsize_r) begin
            res_status_r <= ST_TOO_LARGE;
            state_r      <= S_EMIT;
          end else if (free_head_r < EMPTY) begin
            // link RAM read of the head is under way
            idx_r   <= free_head_r;
            state_r <= S_POP;
          end else if (untouched_r < active) begin
            idx_r       <= untouched_r;
            untouched_r <= untouched_r + IDX_W'(1);
            state_r     <= S_AMUL;
          end else begin
            res_status_r <= ST_OOM;
            state_r      <= S_EMIT;
          end
        end

        S_POP: begin
          free_head_r <= (link_rd_data > EMPTY) ? EMPTY : link_rd_data;
          state_r     <= S_AMUL;
        end

        S_AMUL: begin
          prod_r  <= mul_p;
          state_r <= S_AADD;
        end

        S_AADD: begin
          res_addr_r   <= alu_masked[BADDR_W-1:0];
          res_status_r <= ST_OK;
          allocs_r     <= allocs_r + TOTAL_W'(1);
          bytes_r      <= bytes_r + BYTES_W'(req_r);
          blocks_r     <= blocks_r + BLOCKS_W'(1);
          state_r      <= S_EMIT;
        end

        S_FMUL: begin
          prod_r  <= mul_p;
          state_r <= S_FCHK;
        end

        S_FCHK: begin
          if (alu_carry) begin
            // offset at or past the pool limit, or block size zero
            res_status_r <= ST_BAD_PTR;
            state_r      <= S_EMIT;
          end else begin
            rem_r   <= offset_r[RW-1:0];
            div_r   <= RW'(bsize_r) << (AW - 1);
            quo_r   <= '0;
            cnt_r   <= CW'(AW - 1);
            state_r <= S_FDIV;
          end
        end

        S_FDIV: begin
          if (alu_carry) begin
            rem_r <= alu_res[RW-1:0];
          end
          quo_r <= (quo_r << 1) | AW'(alu_carry);
          div_r <= div_r >> 1;
          if (cnt_r == '0) begin
            state_r <= S_FREM;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end

        S_FREM: begin
          if (rem_r != '0) begin
            res_status_r <= ST_BAD_PTR;
            state_r      <= S_EMIT;
          end else begin
            // size RAM read at the quotient is under way
            idx_r   <= IDX_W'(quo_r);
            state_r <= S_FRD;
          end
        end

        S_FRD: begin
          bytes_r      <= bytes_r - BYTES_W'(size_rd_data);
          blocks_r     <= blocks_r - BLOCKS_W'(1);
          frees_r      <= frees_r + TOTAL_W'(1);
          free_head_r  <= idx_r;
          res_status_r <= ST_OK;
          state_r      <= S_EMIT;
        end

        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_bytes_r  <= bytes_r;
            out_blocks_r <= blocks_r;
            out_allocs_r <= allocs_r;
            out_frees_r  <= frees_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                       out_frees_r, out_allocs_r, out_blocks_r, out_bytes_r, out_addr_r};

  // Free-list head is a block index or the empty marker
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= EMPTY)
    else $error("free list head beyond empty marker");

  // Untouched pointer never runs past the pool
  a_untouched_range: assert property (@(posedge clk) disable iff (!rst_n)
    untouched_r <= EMPTY)
    else $error("untouched pointer beyond pool");

  // One request at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request accepted while busy");

  // A new result only appears from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit step");

  // The quotient of a free within the limit is a block in the pool
  a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREM) |-> (IDX_W'(quo_r) < active))
    else $error("block index out of pool range");

endmodule
